### rtl/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared constants, register indexes and result type of the page packer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

  localparam int PANEL_WIDTH    = 128;
  localparam int PANEL_HEIGHT   = 64;
  localparam int MAX_IMAGE_SIDE = 256;

  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int ROW_W  = $clog2(PANEL_HEIGHT);
  localparam int DIM_W  = $clog2(MAX_IMAGE_SIDE) + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_COL    = 3'd0,
    REG_WIN_ROW    = 3'd1,
    REG_IMG_WIDTH  = 3'd2,
    REG_IMG_HEIGHT = 3'd3,
    REG_THRESHOLD  = 3'd4
  } gtp_reg_t;

  typedef struct packed {
    logic [7:0] page_byte;
    logic [2:0] page;
    logic [6:0] column;
    logic       last;
  } gtp_result_t;

endpackage

`default_nettype wire

### rtl/gray_to_page_mono_packer.sv
// ----------------------------------------------------------------------------
// gray_to_page_mono_packer
// Thresholds raster grayscale pixels and packs them into page bytes of a
// mono panel, one byte per column and 8-row page.
// ----------------------------------------------------------------------------
// channel   signals                                  direction
// in        in_valid/in_ready, frame_start, pixel    request into block
// out       out_valid/out_ready, page_byte, page,     request out of block
//           column, last
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//
// One pixel per cycle while in_ready is high. Each pixel reads its column's
// stripe byte in the accept cycle and writes it back the next cycle; a
// same-column hit on the following pixel is forwarded. Results pass through
// the write-back stage and the output buffer. Reset restores the register
// defaults and clears counters, frame flag and pipeline; the stripe memory
// needs no clearing since each page's top row overwrites its byte. in_ready
// drops only when the two-entry output buffer would fill.
// ----------------------------------------------------------------------------
`default_nettype none

module gray_to_page_mono_packer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           frame_start,
  input  wire logic [7:0]                     pixel,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          page_byte,
  output logic [2:0]                          page,
  output logic [6:0]                          column,
  output logic                                last,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gtp_pkg::*;

  // configuration
  logic [COL_W-1:0] win_col;
  logic [ROW_W-1:0] win_row;
  logic [DIM_W-1:0] img_width;
  logic [DIM_W-1:0] img_height;
  logic [7:0]       threshold;

  // frame position
  logic [DIM_W-1:0] col_count;
  logic [DIM_W-1:0] row_count;
  logic             active;
  logic [DIM_W-1:0] col_count_next;
  logic [DIM_W-1:0] row_count_next;
  logic             active_next;

  // stripe memory
  logic [7:0]       stripe_mem [PANEL_WIDTH];
  logic [7:0]       rd_data;

  // write-back stage
  logic             s1_valid;
  logic [COL_W-1:0] s1_addr;
  logic [2:0]       s1_bitpos;
  logic             s1_bit;
  logic             s1_emit;
  logic [2:0]       s1_page;
  logic             s1_last;
  logic             s1_fwd;
  logic [7:0]       s1_fwd_data;
  logic [7:0]       s1_base;
  logic [7:0]       s1_byte;

  // accept-stage decode
  logic             in_fire;
  logic             place_ok;
  logic             run;
  logic [DIM_W-1:0] c0;
  logic [DIM_W-1:0] r0;
  logic [DIM_W-1:0] c;
  logic [DIM_W-1:0] r;
  logic [DIM_W-1:0] c_inc;
  logic [DIM_W-1:0] r_inc;
  logic [DIM_W-1:0] col_room;
  logic [DIM_W-1:0] row_room;
  logic [DIM_W-1:0] ncols;
  logic [DIM_W-1:0] nrows;
  logic             in_row_range;
  logic             hit;
  logic [COL_W-1:0] pcol;
  logic [ROW_W:0]   prow;
  logic             row_end;
  logic             emit;
  logic             is_last;

  gtp_result_t      res;
  gtp_result_t      out_data;
  logic             space_ok;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = space_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_col    <= '0;
      win_row    <= '0;
      img_width  <= DIM_W'(PANEL_WIDTH);
      img_height <= DIM_W'(PANEL_HEIGHT);
      threshold  <= 8'd127;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIN_COL:    win_col    <= cfg_data[COL_W-1:0];
        REG_WIN_ROW:    win_row    <= cfg_data[ROW_W-1:0];
        REG_IMG_WIDTH:  img_width  <= cfg_data[DIM_W-1:0];
        REG_IMG_HEIGHT: img_height <= cfg_data[DIM_W-1:0];
        REG_THRESHOLD:  threshold  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    place_ok = (win_row[2:0] == 3'd0) &&
               (img_width != '0) && (img_height != '0) &&
               (img_width <= DIM_W'(MAX_IMAGE_SIDE)) &&
               (img_height <= DIM_W'(MAX_IMAGE_SIDE));

    c0 = frame_start ? '0 : col_count;
    r0 = frame_start ? '0 : row_count;
    run = (frame_start ? 1'b1 : active) && place_ok;

    if (c0 >= img_width) begin
      c = '0;
      r = r0 + DIM_W'(1);
    end else begin
      c = c0;
      r = r0;
    end
    in_row_range = (r < img_height);

    col_room = DIM_W'(PANEL_WIDTH) - DIM_W'(win_col);
    row_room = DIM_W'(PANEL_HEIGHT) - DIM_W'(win_row);
    ncols = (img_width < col_room) ? img_width : col_room;
    nrows = (img_height < row_room) ? img_height : row_room;

    hit     = run && in_row_range && (c < ncols) && (r < nrows);
    pcol    = COL_W'(DIM_W'(win_col) + c);
    prow    = (ROW_W+1)'(win_row) + (ROW_W+1)'(r);
    row_end = (r == nrows - DIM_W'(1));
    emit    = (r[2:0] == 3'd7) || row_end;
    is_last = row_end && (c == ncols - DIM_W'(1));

    c_inc = c + DIM_W'(1);
    r_inc = r + DIM_W'(1);

    // default: hold, or restart on a frame marker
    col_count_next = c0;
    row_count_next = r0;
    active_next    = frame_start ? place_ok : active;
    if (run) begin
      if (!in_row_range) begin
        col_count_next = c;
        row_count_next = r;
        active_next    = 1'b0;
      end else if (c_inc >= img_width) begin
        col_count_next = '0;
        row_count_next = r_inc;
        active_next    = (r_inc < img_height);
      end else begin
        col_count_next = c_inc;
        row_count_next = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      active    <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= in_fire && hit;
      if (in_fire) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
        active    <= active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && hit) begin
      s1_addr     <= pcol;
      s1_bitpos   <= r[2:0];
      s1_bit      <= (pixel > threshold);
      s1_emit     <= emit;
      s1_page     <= prow[ROW_W-1:3];
      s1_last     <= is_last;
      s1_fwd      <= s1_valid && (s1_addr == pcol);
      s1_fwd_data <= s1_byte;
    end
  end

  // read in the accept cycle, write back in the next cycle
  always_ff @(posedge clk) begin
    if (in_fire && hit) begin
      rd_data <= stripe_mem[pcol];
    end
    if (s1_valid) begin
      stripe_mem[s1_addr] <= s1_byte;
    end
  end

  always_comb begin
    s1_base = s1_fwd ? s1_fwd_data : rd_data;
    if (s1_bitpos == 3'd0) begin
      s1_byte = {7'd0, s1_bit};
    end else begin
      s1_byte = (s1_base & ~(8'd1 << s1_bitpos)) | ({7'd0, s1_bit} << s1_bitpos);
    end
    res.page_byte = s1_byte;
    res.page      = s1_page;
    res.column    = s1_addr;
    res.last      = s1_last;
  end

  gtp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid && s1_emit),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .space_ok  (space_ok)
  );

  assign page_byte = out_data.page_byte;
  assign page      = out_data.page;
  assign column    = out_data.column;
  assign last      = out_data.last;

  a_s1_from_accept: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(in_fire))
    else $error("write-back stage without an accepted request");
  a_idle_no_work: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !frame_start && !active) |=> !s1_valid)
    else $error("idle request reached the stripe memory");
  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (in_fire && hit && s1_valid && s1_addr == pcol) |=> (s1_fwd && s1_valid))
    else $error("back-to-back same-column update not forwarded");

endmodule

`default_nettype wire

### rtl/gtp_out_fifo.sv
// ----------------------------------------------------------------------------
// gtp_out_fifo
// Two-entry output buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module gtp_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire gtp_pkg::gtp_result_t push_data,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output gtp_pkg::gtp_result_t      out_data,
  output logic                      space_ok
);
  import gtp_pkg::*;

  gtp_result_t entry [2];
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic [1:0]  wr_idx;
  logic        pop;

  assign out_valid  = (count != 2'd0);
  assign out_data   = entry[0];
  assign pop        = out_valid && out_ready;
  assign count_next = count + {1'b0, push} - {1'b0, pop};
  assign wr_idx     = count - {1'b0, pop};
  assign space_ok   = (count_next < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && wr_idx == 2'd0) begin
      entry[0] <= push_data;
    end else if (pop) begin
      entry[0] <= entry[1];
    end
    if (push && wr_idx == 2'd1) begin
      entry[1] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("output buffer level out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd2) |-> pop)
    else $error("push into full output buffer");

endmodule

`default_nettype wire

### verif/gray_to_page_mono_packer_tb.sv
// ----------------------------------------------------------------------------
// gray_to_page_mono_packer_tb
// Self-checking bench for the page packer. A queued driver feeds pixel and
// register requests under random idling and output stalls; a monitor keeps a
// cycle-free model of the stripe packing and compares every page byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gray_to_page_mono_packer_tb;
  import gtp_pkg::*;

  localparam int ITEMS    = 1000;
  localparam int TAIL_LEN = 100;
  localparam int SETTLE   = 8;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic                  fs;
    logic [7:0]            px;
    gtp_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  frame_start = 1'b0;
  logic [7:0]            pixel = 8'd0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            page_byte;
  logic [2:0]            page;
  logic [6:0]            column;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  gtp_reg_t              cfg_index = REG_WIN_COL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  step_t       pending[$];
  gtp_result_t page_bytes_due[$];
  int          errors = 0;
  int          useful = 0;
  int          gap_left = 0;
  int          ready_left = 0;
  int          quiet = 0;
  logic        in_took = 1'b0;
  logic        cfg_took = 1'b0;

  logic [6:0]  win_col_q;
  logic [5:0]  win_row_q;
  logic [8:0]  img_w_q;
  logic [8:0]  img_h_q;
  logic [7:0]  thresh_q;
  logic [7:0]  stripe_q [0:PANEL_WIDTH-1];
  int          col_pos;
  int          row_pos;
  bit          frame_on;

  gray_to_page_mono_packer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_start(frame_start),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .page_byte  (page_byte),
    .page       (page),
    .column     (column),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic bit window_fits();
    return win_row_q[2:0] == 3'd0 && img_w_q != 9'd0 && img_h_q != 9'd0 &&
           img_w_q <= MAX_IMAGE_SIDE && img_h_q <= MAX_IMAGE_SIDE;
  endfunction

  function automatic void apply_reg(gtp_reg_t idx, logic [CFG_DATA_W-1:0] d);
    unique case (idx)
      REG_WIN_COL:    win_col_q = d[6:0];
      REG_WIN_ROW:    win_row_q = d[5:0];
      REG_IMG_WIDTH:  img_w_q   = d;
      REG_IMG_HEIGHT: img_h_q   = d;
      REG_THRESHOLD:  thresh_q  = d[7:0];
      default: ;
    endcase
  endfunction

  function automatic void pack_pixel(logic fs, logic [7:0] px);
    int          ncols, nrows, c, r, pcol, bitpos, pg;
    logic        lit;
    logic [7:0]  b;
    gtp_result_t res;
    if (fs) begin
      col_pos  = 0;
      row_pos  = 0;
      frame_on = window_fits();
    end
    if (!frame_on || !window_fits()) return;
    if (col_pos >= img_w_q) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= img_h_q) begin
      frame_on = 1'b0;
      return;
    end
    ncols = PANEL_WIDTH - int'(win_col_q);
    if (img_w_q < ncols) ncols = int'(img_w_q);
    nrows = PANEL_HEIGHT - int'(win_row_q);
    if (img_h_q < nrows) nrows = int'(img_h_q);
    c = col_pos;
    r = row_pos;
    if (c < ncols && r < nrows) begin
      pcol   = int'(win_col_q) + c;
      bitpos = r % 8;
      lit    = px > thresh_q;
      b      = (bitpos == 0) ? 8'd0 : stripe_q[pcol];
      b[bitpos] = lit;
      stripe_q[pcol] = b;
      if (bitpos == 7 || r == nrows - 1) begin
        pg            = (int'(win_row_q) + r) >> 3;
        res.page_byte = b;
        res.page      = pg[2:0];
        res.column    = pcol[6:0];
        res.last      = (r == nrows - 1) && (c == ncols - 1);
        page_bytes_due.push_back(res);
      end
    end
    col_pos = c + 1;
    if (col_pos >= img_w_q) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= img_h_q) frame_on = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : watch_outputs
    int          i;
    gtp_result_t want;
    if (rst) begin
      win_col_q = '0;
      win_row_q = '0;
      img_w_q   = 9'd128;
      img_h_q   = 9'd64;
      thresh_q  = 8'd127;
      for (i = 0; i < PANEL_WIDTH; i++) stripe_q[i] = 8'd0;
      col_pos  = 0;
      row_pos  = 0;
      frame_on = 1'b0;
      in_took  <= 1'b0;
      cfg_took <= 1'b0;
      quiet    <= 0;
    end else begin
      in_took  <= in_valid && in_ready;
      cfg_took <= cfg_valid && cfg_ready;
      quiet    <= (in_valid && in_ready) ? 0 : (quiet < 1000 ? quiet + 1 : quiet);
      if (out_valid && out_ready) begin
        if (page_bytes_due.size() == 0) begin
          errors++;
          $error("unexpected page byte %0d at page %0d column %0d", page_byte, page, column);
        end else begin
          want = page_bytes_due.pop_front();
          if (page_byte !== want.page_byte) begin
            errors++;
            $error("page_byte: expected %0d, got %0d", want.page_byte, page_byte);
          end
          if (page !== want.page) begin
            errors++;
            $error("page: expected %0d, got %0d", want.page, page);
          end
          if (column !== want.column) begin
            errors++;
            $error("column: expected %0d, got %0d", want.column, column);
          end
          if (last !== want.last) begin
            errors++;
            $error("last: expected %0d, got %0d", want.last, last);
          end
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) pack_pixel(frame_start, pixel);
    end
  end

  always @(negedge clk) begin : drive_requests
    logic  nv, ncv;
    step_t s;
    nv  = in_valid && !in_took;
    ncv = cfg_valid && !cfg_took;
    if (!rst && !nv && !ncv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0) begin
        s = pending[0];
        if (s.kind == STEP_PIXEL) begin
          s = pending.pop_front();
          nv = 1'b1;
          frame_start <= s.fs;
          pixel       <= s.px;
          if (pending.size() >= TAIL_LEN && $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, 4);
        end else if (page_bytes_due.size() == 0 && quiet >= SETTLE) begin
          s = pending.pop_front();
          ncv = 1'b1;
          cfg_index <= s.idx;
          cfg_data  <= s.data;
        end
      end
    end
    in_valid  <= nv;
    cfg_valid <= ncv;
  end

  always @(negedge clk) begin : drive_ready
    if (pending.size() < TAIL_LEN) begin
      out_ready  <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(0, 10);
    end else begin
      out_ready  <= 1'b0;
      ready_left = $urandom_range(0, 3);
    end
  end

  function automatic logic [7:0] shade(int thr);
    int v;
    case ($urandom_range(0, 3))
      0:       v = thr;
      1:       v = thr + 1;
      default: v = $urandom_range(0, 255);
    endcase
    return v[7:0];
  endfunction

  task automatic put_pixel(logic fs, logic [7:0] px);
    step_t s;
    s.kind = STEP_PIXEL;
    s.fs   = fs;
    s.px   = px;
    s.idx  = REG_WIN_COL;
    s.data = '0;
    pending.push_back(s);
  endtask

  task automatic put_reg(gtp_reg_t idx, int val);
    step_t s;
    s.kind = STEP_REG;
    s.fs   = 1'b0;
    s.px   = 8'd0;
    s.idx  = idx;
    s.data = val[CFG_DATA_W-1:0];
    pending.push_back(s);
  endtask

  task automatic set_window(int wc, int wr, int w, int h, int thr);
    put_reg(REG_WIN_COL, wc);
    put_reg(REG_WIN_ROW, wr);
    put_reg(REG_IMG_WIDTH, w);
    put_reg(REG_IMG_HEIGHT, h);
    put_reg(REG_THRESHOLD, thr);
  endtask

  task automatic put_image(int n, int thr);
    int i;
    for (i = 0; i < n; i++) put_pixel(i == 0, shade(thr));
    useful += n;
  endtask

  initial begin : run
    int wc, wr, w, h, thr, nfr, f, mode, n, r0, c0, newh, i, sel, waited;
    int wide_left, tall_left;
    bit good;

    put_pixel(1'b0, 8'hFF);
    put_pixel(1'b0, 8'h00);
    // right-edge clip with a short last stripe
    set_window(126, 56, 3, 3, 0);
    for (i = 0; i < 9; i++) put_pixel(i == 0, (i % 2) ? 8'hFF : ((i % 4) ? 8'h01 : 8'h00));
    put_pixel(1'b0, 8'h80);
    // rejected placements
    set_window(0, 3, 3, 3, 127);
    put_pixel(1'b1, 8'hFF);
    put_reg(REG_WIN_ROW, 0);
    put_reg(REG_IMG_WIDTH, 0);
    put_pixel(1'b1, 8'hFF);
    put_reg(REG_IMG_WIDTH, 300);
    put_pixel(1'b1, 8'hFF);
    // abandon a frame, then a bottom-clipped one
    set_window(0, 56, 1, 9, 255);
    put_pixel(1'b1, 8'hC8);
    put_pixel(1'b0, 8'hFF);
    for (i = 0; i < 9; i++) put_pixel(i == 0, (i % 3) ? 8'hFF : 8'hFE);

    wide_left = 2;
    tall_left = 2;
    while (useful < ITEMS) begin
      wc = ($urandom_range(0, 2) == 0) ? $urandom_range(116, 127) : $urandom_range(0, 127);
      wr = 8 * $urandom_range(0, 7);
      if ($urandom_range(0, 14) == 0) wr = wr + $urandom_range(1, 7);
      w   = $urandom_range(1, 12);
      h   = $urandom_range(1, 18);
      thr = $urandom_range(0, 255);
      sel = $urandom_range(0, 29);
      if (sel == 0) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
      end else if (sel == 1) begin
        h = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
      end else if (sel == 2 && wide_left > 0 && useful < ITEMS / 2) begin
        w = 256;
        h = $urandom_range(1, 2);
        wide_left--;
      end else if (sel == 3 && tall_left > 0 && useful < ITEMS / 2) begin
        w = 1;
        h = 256;
        tall_left--;
      end
      set_window(wc, wr, w, h, thr);
      good = (wr % 8 == 0) && w >= 1 && w <= 256 && h >= 1 && h <= 256;
      nfr  = (good && w * h > 64) ? 1 : $urandom_range(1, 3);
      for (f = 0; f < nfr; f++) begin
        mode = $urandom_range(0, 9);
        if (!good) begin
          put_pixel(1'b1, 8'($urandom_range(0, 255)));
          put_pixel(1'b0, 8'($urandom_range(0, 255)));
        end else if (mode == 0 && w * h > 1) begin
          put_image($urandom_range(1, w * h - 1), thr);
          put_image(w * h, thr);
        end else if (mode == 1 && h > 1) begin
          // shrink height and move threshold while the frame runs
          r0 = $urandom_range(1, h - 1);
          c0 = $urandom_range(0, w - 1);
          put_image(r0 * w + c0, thr);
          newh = r0 + $urandom_range(0, 1);
          thr  = $urandom_range(0, 255);
          put_reg(REG_THRESHOLD, thr);
          put_reg(REG_IMG_HEIGHT, newh);
          n = (newh > r0) ? w - c0 : 0;
          for (i = 0; i < n; i++) put_pixel(1'b0, shade(thr));
          put_pixel(1'b0, shade(thr));
          useful += n;
          h = newh;
        end else begin
          put_image(w * h, thr);
        end
        if ($urandom_range(0, 5) == 0) put_pixel(1'b0, 8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending.size() > 0 || in_valid || cfg_valid) @(posedge clk);
    waited = 0;
    while (page_bytes_due.size() > 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (page_bytes_due.size() > 0) begin
      errors++;
      $error("%0d page bytes never arrived", page_bytes_due.size());
    end
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
